>>> design/matrix_add_multiply_defines.svh
// ----------------------------------------------------------------------------
// matrix_add_multiply_defines
// Assertion macros shared by the matrix add/multiply RTL.
// ----------------------------------------------------------------------------
`ifndef MATRIX_ADD_MULTIPLY_DEFINES_SVH
`define MATRIX_ADD_MULTIPLY_DEFINES_SVH

// Checked on every clock edge outside reset.
`define MAM_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define MAM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/mam_pkg.sv
// ----------------------------------------------------------------------------
// mam_pkg
// Types, codes and constants of the matrix add/multiply block.
// ----------------------------------------------------------------------------
package mam_pkg;

  localparam int IN_W       = 16;  // element_value port width
  localparam int VALUE_W    = 35;  // result_value width, Q19.16
  localparam int IDX_W      = 3;   // row / column index width
  localparam int DIM_W      = 4;   // dimension register width
  localparam int CNT_W      = 2 * DIM_W;
  localparam int MIN_DIM    = 2;
  localparam int FRAC_SHIFT = 8;   // Q8.8 to Q16.16

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_ADD    = 2'd2,
    OP_MUL    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_ROWS_A = 2'd0,
    REG_COLS_A = 2'd1,
    REG_ROWS_B = 2'd2,
    REG_COLS_B = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOT_LOADED   = 2'd1,
    ST_DIM_MISMATCH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_MUL,
    CMD_ERR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    status_t   status;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic [DIM_W-1:0] ra;
    logic [DIM_W-1:0] ca;
    logic [DIM_W-1:0] rb;
    logic [DIM_W-1:0] cb;
  } dims_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                 input logic [DIM_W-1:0] max_d);
    logic [DIM_W-1:0] res;
    res = d;
    if (d < DIM_W'(MIN_DIM)) res = DIM_W'(MIN_DIM);
    else if (d > max_d)      res = max_d;
    return res;
  endfunction

endpackage

>>> design/matrix_add_multiply.sv
// Load items: one per cycle, accepted only while no add/multiply is pending.
// Add: one result per cycle while result_stall is low.
// Multiply: one result per output element, summed over cols_a products in a single MAC.
// Error results: one item with value, row and column zero, flagged last.
// Reset: dimensions return to 2, both matrices not loaded, fill pointers 0;
// store contents are undefined until loaded.
// ----------------------------------------------------------------------------
// matrix_add_multiply
// Matrix store with element-wise add and product of two loaded matrices.
// ----------------------------------------------------------------------------
module matrix_add_multiply import mam_pkg::*; #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                write_enable,
  input  logic [1:0]          write_index,
  input  logic [DIM_W-1:0]    write_data,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [1:0]          opcode,
  input  logic [IN_W-1:0]     element_value,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [VALUE_W-1:0]  result_value,
  output logic [IDX_W-1:0]    result_row,
  output logic [IDX_W-1:0]    result_col,
  output logic [1:0]          status,
  output logic                last
);

  localparam int SW    = (ELEM_WIDTH < IN_W) ? ELEM_WIDTH : IN_W;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  logic [DIM_W-1:0] rows_a, cols_a, rows_b, cols_b;
  dims_t            dims;
  logic             a_we, b_we, push, pop, q_valid, back_idle, rd_en;
  logic [AW-1:0]    wr_addr, a_raddr, b_raddr;
  logic [SW-1:0]    wr_data, a_rdata, b_rdata;
  cmd_t             push_cmd, head;
  q_stat_t          qs;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= DIM_W'(MIN_DIM);
      cols_a <= DIM_W'(MIN_DIM);
      rows_b <= DIM_W'(MIN_DIM);
      cols_b <= DIM_W'(MIN_DIM);
    end else if (write_enable) begin
      case (cfg_reg_t'(write_index))
        REG_ROWS_A: rows_a <= write_data;
        REG_COLS_A: cols_a <= write_data;
        REG_ROWS_B: rows_b <= write_data;
        REG_COLS_B: cols_b <= write_data;
        default:    rows_a <= rows_a;
      endcase
    end
  end

  assign dims.ra = clamp_dim(rows_a, DIM_W'(MAX_DIM));
  assign dims.ca = clamp_dim(cols_a, DIM_W'(MAX_DIM));
  assign dims.rb = clamp_dim(rows_b, DIM_W'(MAX_DIM));
  assign dims.cb = clamp_dim(cols_b, DIM_W'(MAX_DIM));

  mam_front #(.MAX_DIM(MAX_DIM), .SW(SW)) u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .opcode        (opcode),
    .element_value (element_value),
    .dims          (dims),
    .back_idle     (back_idle),
    .qs            (qs),
    .a_we          (a_we),
    .b_we          (b_we),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  mam_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mam_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  mam_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head),
    .qs       (qs)
  );

  mam_back #(.MAX_DIM(MAX_DIM), .SW(SW)) u_back (
    .clk          (clk),
    .rst          (rst),
    .dims         (dims),
    .q_valid      (q_valid),
    .head         (head),
    .pop          (pop),
    .back_idle    (back_idle),
    .rd_en        (rd_en),
    .a_raddr      (a_raddr),
    .b_raddr      (b_raddr),
    .a_rdata      (a_rdata),
    .b_rdata      (b_rdata),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_value (result_value),
    .result_row   (result_row),
    .result_col   (result_col),
    .status       (status),
    .last         (last)
  );

endmodule

>>> design/mam_ram.sv
// ----------------------------------------------------------------------------
// mam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/mam_front.sv
// ----------------------------------------------------------------------------
// mam_front
// Accepts items: writes loads into the stores, classifies add/multiply
// items into commands for the back end.
// ----------------------------------------------------------------------------
`include "matrix_add_multiply_defines.svh"

module mam_front import mam_pkg::*; #(
  parameter int MAX_DIM = 8,
  parameter int SW      = 16,
  localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic [1:0]       opcode,
  input  logic [IN_W-1:0]  element_value,
  input  dims_t            dims,
  input  logic             back_idle,
  input  q_stat_t          qs,
  output logic             a_we,
  output logic             b_we,
  output logic [AW-1:0]    wr_addr,
  output logic [SW-1:0]    wr_data,
  output logic             push,
  output cmd_t             push_cmd
);

  logic [AW-1:0]    a_ptr, b_ptr;
  logic             a_loaded, b_loaded;
  logic [AW-1:0]    a_base, b_base;
  logic [AW:0]      a_inc, b_inc;
  logic [CNT_W-1:0] a_count, b_count;
  logic             a_done, b_done;
  logic             is_load, accept;
  opcode_t          op;

  assign op      = opcode_t'(opcode);
  assign is_load = (op == OP_LOAD_A) || (op == OP_LOAD_B);

  // loads touch the stores, so they wait until no command is pending
  assign item_stall = is_load ? !(back_idle && qs.empty) : qs.full;
  assign accept     = item_valid && !item_stall;

  assign a_count = CNT_W'(dims.ra) * CNT_W'(dims.ca);
  assign b_count = CNT_W'(dims.rb) * CNT_W'(dims.cb);

  // a new load into a complete matrix restarts at element 0
  assign a_base = a_loaded ? '0 : a_ptr;
  assign b_base = b_loaded ? '0 : b_ptr;
  assign a_inc  = {1'b0, a_base} + (AW+1)'(1);
  assign b_inc  = {1'b0, b_base} + (AW+1)'(1);
  assign a_done = CNT_W'(a_inc) >= a_count;
  assign b_done = CNT_W'(b_inc) >= b_count;

  assign a_we    = accept && (op == OP_LOAD_A);
  assign b_we    = accept && (op == OP_LOAD_B);
  assign wr_addr = (op == OP_LOAD_B) ? b_base : a_base;
  assign wr_data = element_value[SW-1:0];

  assign push = accept && !is_load;

  always_comb begin
    push_cmd.kind   = CMD_ERR;
    push_cmd.status = ST_NOT_LOADED;
    if (a_loaded && b_loaded) begin
      push_cmd.status = ST_DIM_MISMATCH;
      case (op)
        OP_ADD: begin
          if (dims.ra == dims.rb && dims.ca == dims.cb) begin
            push_cmd.kind   = CMD_ADD;
            push_cmd.status = ST_OK;
          end
        end
        OP_MUL: begin
          if (dims.ca == dims.rb) begin
            push_cmd.kind   = CMD_MUL;
            push_cmd.status = ST_OK;
          end
        end
        default: begin
          push_cmd.kind = CMD_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ptr    <= '0;
      b_ptr    <= '0;
      a_loaded <= 1'b0;
      b_loaded <= 1'b0;
    end else begin
      if (a_we) begin
        a_loaded <= a_done;
        a_ptr    <= a_done ? '0 : a_inc[AW-1:0];
      end
      if (b_we) begin
        b_loaded <= b_done;
        b_ptr    <= b_done ? '0 : b_inc[AW-1:0];
      end
    end
  end

  `MAM_ASSERT_CLK(a_loaded_ptr_zero, !a_loaded || a_ptr == '0, "A loaded with pointer set")
  `MAM_ASSERT_CLK(b_loaded_ptr_zero, !b_loaded || b_ptr == '0, "B loaded with pointer set")
  `MAM_ASSERT_CLK(load_only_idle, !(a_we || b_we) || (back_idle && qs.empty),
                  "store written while commands pending")

endmodule

>>> design/mam_queue.sv
// ----------------------------------------------------------------------------
// mam_queue
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
`include "matrix_add_multiply_defines.svh"

module mam_queue import mam_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output logic    q_valid,
  output cmd_t    head,
  output q_stat_t qs
);

  localparam int DEPTH = 2;

  cmd_t       entries [DEPTH];
  logic       wptr, rptr;
  logic [1:0] count;

  assign q_valid  = (count != 2'd0);
  assign head     = entries[rptr];
  assign qs.empty = (count == 2'd0);
  assign qs.full  = (count == 2'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        entries[wptr] <= push_cmd;
        wptr          <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `MAM_ASSERT_ALWAYS(no_overflow, !(push && qs.full && !pop), "command queue overflow")
  `MAM_ASSERT_CLK(no_underflow, !(pop && qs.empty), "command queue underflow")

endmodule

>>> design/mam_back.sv
// ----------------------------------------------------------------------------
// mam_back
// Runs add/multiply and error commands: address sequencer, store read, one MAC,
// output register.
// ----------------------------------------------------------------------------
`include "matrix_add_multiply_defines.svh"

module mam_back import mam_pkg::*; #(
  parameter int MAX_DIM = 8,
  parameter int SW      = 16,
  localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                clk,
  input  logic                rst,
  input  dims_t               dims,
  input  logic                q_valid,
  input  cmd_t                head,
  output logic                pop,
  output logic                back_idle,
  output logic                rd_en,
  output logic [AW-1:0]       a_raddr,
  output logic [AW-1:0]       b_raddr,
  input  logic [SW-1:0]       a_rdata,
  input  logic [SW-1:0]       b_rdata,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [VALUE_W-1:0]  result_value,
  output logic [IDX_W-1:0]    result_row,
  output logic [IDX_W-1:0]    result_col,
  output logic [1:0]          status,
  output logic                last
);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  typedef struct packed {
    logic             add;
    status_t          status;
    logic             first;
    logic             done;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  state_t                     state;
  cmd_kind_t                  kind;
  status_t                    err_status;
  logic [IDX_W-1:0]           r, c, t;
  logic [AW-1:0]              a_addr, b_addr, row_base;
  logic                       r_last, c_last, t_last, op_end, adv;
  tag_t                       tag_now, s1, s2;
  logic                       s1_valid, s2_valid;
  logic signed [VALUE_W-1:0]  s2_term, acc, sum;
  logic signed [SW-1:0]       a_s, b_s;
  logic signed [SW:0]         add_res;
  logic signed [2*SW-1:0]     mul_res;

  // the whole pipeline moves only when the output register is free
  assign adv       = !result_valid || !result_stall;
  assign pop       = (state == S_IDLE) && q_valid;
  assign back_idle = (state == S_IDLE);
  assign rd_en     = adv;
  assign a_raddr   = a_addr;
  assign b_raddr   = b_addr;

  assign r_last = (DIM_W'(r) + DIM_W'(1)) == dims.ra;
  assign t_last = (DIM_W'(t) + DIM_W'(1)) == dims.ca;
  assign c_last = (DIM_W'(c) + DIM_W'(1)) == ((kind == CMD_ADD) ? dims.ca : dims.cb);
  assign op_end = (kind == CMD_ERR) || (r_last && c_last && (kind == CMD_ADD || t_last));

  always_comb begin
    tag_now.add    = (kind == CMD_ADD);
    tag_now.status = (kind == CMD_ERR) ? err_status : ST_OK;
    tag_now.first  = (t == '0);
    tag_now.done   = (kind != CMD_MUL) || t_last;
    tag_now.last   = op_end;
    tag_now.row    = (kind == CMD_ERR) ? '0 : r;
    tag_now.col    = (kind == CMD_ERR) ? '0 : c;
  end

  assign a_s     = a_rdata;
  assign b_s     = b_rdata;
  assign add_res = (SW+1)'(a_s) + (SW+1)'(b_s);
  assign mul_res = a_s * b_s;
  assign sum     = s2.first ? s2_term : acc + s2_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            state      <= S_RUN;
            kind       <= head.kind;
            err_status <= head.status;
            r          <= '0;
            c          <= '0;
            t          <= '0;
            a_addr     <= '0;
            b_addr     <= '0;
            row_base   <= '0;
          end
        end
        S_RUN: begin
          if (adv) begin
            if (op_end) begin
              state <= S_IDLE;
            end else if (kind == CMD_MUL && !t_last) begin
              t      <= t + IDX_W'(1);
              a_addr <= a_addr + AW'(1);
              b_addr <= b_addr + AW'(dims.cb);
            end else if (!c_last) begin
              t <= '0;
              c <= c + IDX_W'(1);
              if (kind == CMD_ADD) begin
                a_addr <= a_addr + AW'(1);
                b_addr <= b_addr + AW'(1);
              end else begin
                a_addr <= row_base;
                b_addr <= AW'(c + IDX_W'(1));
              end
            end else begin
              // next row
              t        <= '0;
              c        <= '0;
              r        <= r + IDX_W'(1);
              row_base <= row_base + AW'(dims.ca);
              a_addr   <= row_base + AW'(dims.ca);
              b_addr   <= (kind == CMD_ADD) ? row_base + AW'(dims.ca) : '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (adv) begin
        s1_valid     <= (state == S_RUN);
        s1           <= tag_now;
        s2_valid     <= s1_valid;
        s2           <= s1;
        if (s1.status != ST_OK) begin
          s2_term <= '0;
        end else if (s1.add) begin
          s2_term <= VALUE_W'(add_res) <<< FRAC_SHIFT;
        end else begin
          s2_term <= VALUE_W'(mul_res);
        end
        if (s2_valid) begin
          acc <= sum;
        end
        result_valid <= s2_valid && s2.done;
        if (s2_valid && s2.done) begin
          result_value <= sum;
          result_row   <= s2.row;
          result_col   <= s2.col;
          status       <= s2.status;
          last         <= s2.last;
        end
      end
    end
  end

  `MAM_ASSERT_CLK(err_single, !(result_valid && status != ST_OK) ||
                  (last && result_row == '0 && result_col == '0 && result_value == '0),
                  "error result not a single zero item")
  `MAM_ASSERT_CLK(last_on_final_row, !(result_valid && last && status == ST_OK) ||
                  (DIM_W'(result_row) + DIM_W'(1)) == dims.ra,
                  "last flag before final row")
  `MAM_ASSERT_CLK(err_one_cycle, (state == S_RUN && kind == CMD_ERR && adv) |=> state == S_IDLE,
                  "error command runs more than one step")

endmodule
